// ----- hdl/tssm_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tssm_pkg: shared types and constants for the two-stack memory
// Sizes, command and status codes, sequencer states and the memory request.
// ----------------------------------------------------------------------------
package tssm_pkg;

    // Words in the shared memory; both stacks live in it
    localparam int DEPTH  = 16;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int DATA_W = 32;
    localparam int CMD_W  = 3;
    localparam int STAT_W = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH_ONE = 3'd0,
        CMD_PUSH_TWO = 3'd1,
        CMD_POP_ONE  = 3'd2,
        CMD_POP_TWO  = 3'd3,
        CMD_LIST_ONE = 3'd4,
        CMD_LIST_TWO = 3'd5
    } t_cmd;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_OVER  = 2'd1,
        ST_UNDER = 2'd2
    } t_status;

    typedef enum logic {
        S_IDLE,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic              we;
        logic              re;
        logic [ADDR_W-1:0] addr;
        logic [DATA_W-1:0] wdata;
    } t_mem_req;

endpackage
`default_nettype wire

// ----- hdl/tssm_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tssm_if: command and response channels
// Valid/ready channels; a beat moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface tssm_cmd_if import tssm_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [CMD_W-1:0]         cmd;
    logic signed [DATA_W-1:0] data_value;

    modport source (output valid, cmd, data_value, input ready);
    modport sink   (input valid, cmd, data_value, output ready);
endinterface

interface tssm_rsp_if import tssm_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] value;
    logic [STAT_W-1:0]        status;
    logic                     last;

    modport source (output valid, value, status, last, input ready);
    modport sink   (input valid, value, status, last, output ready);
endinterface
`default_nettype wire

// ----- hdl/tssm_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tssm_ram: simple dual-port synchronous RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module tssm_ram #(
    parameter int WORDS  = 16,
    parameter int ADDR_W = 4,
    parameter int DATA_W = 32
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [DATA_W-1:0] i_wdata,
    input  wire logic              i_re,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] mem [WORDS];

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    // Read port; data holds until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

// ----- hdl/tssm_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tssm_ctrl: command sequencer for the two stacks
// Keeps both stack counts, drives the shared memory and the response register.
// ----------------------------------------------------------------------------
module tssm_ctrl import tssm_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    tssm_cmd_if.sink               i_cmd,
    tssm_rsp_if.source             o_rsp,
    output t_mem_req               o_mem,
    input  wire logic [DATA_W-1:0] i_rd_data
);

    t_state            r_state, n_state;
    logic [CNT_W-1:0]  r_cnt_one, n_cnt_one;
    logic [CNT_W-1:0]  r_cnt_two, n_cnt_two;
    logic [ADDR_W-1:0] r_ptr, n_ptr;
    logic [ADDR_W-1:0] r_end, n_end;
    logic              r_up, n_up;

    logic              r_out_valid;
    logic [DATA_W-1:0] r_out_value, n_out_value;
    t_status           r_out_status, n_out_status;
    logic              r_out_last, n_out_last;
    logic              out_load;

    logic              out_free;
    logic              cmd_fire;
    logic              full;
    logic              one_empty, two_empty;
    logic              start_emit;
    logic              at_end;
    logic [CNT_W:0]    fill_sum;
    logic [CNT_W-1:0]  top_one, top_two, push_two;
    t_cmd              cmd_code;

    // Shared decode
    assign out_free  = !r_out_valid || o_rsp.ready;
    assign i_cmd.ready = (r_state == S_IDLE) && out_free;
    assign cmd_fire  = i_cmd.valid && i_cmd.ready;
    assign cmd_code  = t_cmd'(i_cmd.cmd);
    assign fill_sum  = {1'b0, r_cnt_one} + {1'b0, r_cnt_two};
    assign full      = fill_sum >= (CNT_W + 1)'(DEPTH);
    assign one_empty = (r_cnt_one == '0);
    assign two_empty = (r_cnt_two == '0);
    assign top_one   = r_cnt_one - CNT_W'(1);
    assign top_two   = CNT_W'(DEPTH) - r_cnt_two;
    assign push_two  = CNT_W'(DEPTH - 1) - r_cnt_two;
    assign at_end    = (r_ptr == r_end);

    // Commands that read the memory and stream words out
    always_comb begin
        start_emit = 1'b0;
        if (cmd_fire) begin
            if ((cmd_code == CMD_POP_ONE || cmd_code == CMD_LIST_ONE) && !one_empty) begin
                start_emit = 1'b1;
            end
            if ((cmd_code == CMD_POP_TWO || cmd_code == CMD_LIST_TWO) && !two_empty) begin
                start_emit = 1'b1;
            end
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (start_emit) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (out_free && at_end) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Memory, counts, pointer and response load
    always_comb begin
        n_cnt_one    = r_cnt_one;
        n_cnt_two    = r_cnt_two;
        n_ptr        = r_ptr;
        n_end        = r_end;
        n_up         = r_up;
        out_load     = 1'b0;
        n_out_value  = '0;
        n_out_status = ST_OK;
        n_out_last   = 1'b1;
        o_mem.we     = 1'b0;
        o_mem.re     = 1'b0;
        o_mem.addr   = '0;
        o_mem.wdata  = i_cmd.data_value;
        unique case (r_state)
            S_IDLE: begin
                if (cmd_fire) begin
                    unique case (cmd_code)
                        CMD_PUSH_ONE: begin
                            out_load = 1'b1;
                            if (full) begin
                                n_out_status = ST_OVER;
                            end else begin
                                o_mem.we   = 1'b1;
                                o_mem.addr = r_cnt_one[ADDR_W-1:0];
                                n_cnt_one  = r_cnt_one + CNT_W'(1);
                            end
                        end
                        CMD_PUSH_TWO: begin
                            out_load = 1'b1;
                            if (full) begin
                                n_out_status = ST_OVER;
                            end else begin
                                o_mem.we   = 1'b1;
                                o_mem.addr = push_two[ADDR_W-1:0];
                                n_cnt_two  = r_cnt_two + CNT_W'(1);
                            end
                        end
                        CMD_POP_ONE, CMD_LIST_ONE: begin
                            if (one_empty) begin
                                out_load     = 1'b1;
                                n_out_status = ST_UNDER;
                            end else begin
                                o_mem.re   = 1'b1;
                                o_mem.addr = top_one[ADDR_W-1:0];
                                n_ptr      = top_one[ADDR_W-1:0];
                                n_up       = 1'b0;
                                if (cmd_code == CMD_POP_ONE) begin
                                    n_end     = top_one[ADDR_W-1:0];
                                    n_cnt_one = top_one;
                                end else begin
                                    n_end = '0;
                                end
                            end
                        end
                        CMD_POP_TWO, CMD_LIST_TWO: begin
                            if (two_empty) begin
                                out_load     = 1'b1;
                                n_out_status = ST_UNDER;
                            end else begin
                                o_mem.re   = 1'b1;
                                o_mem.addr = top_two[ADDR_W-1:0];
                                n_ptr      = top_two[ADDR_W-1:0];
                                n_up       = 1'b1;
                                if (cmd_code == CMD_POP_TWO) begin
                                    n_end     = top_two[ADDR_W-1:0];
                                    n_cnt_two = r_cnt_two - CNT_W'(1);
                                end else begin
                                    n_end = ADDR_W'(DEPTH - 1);
                                end
                            end
                        end
                        default: ;  // unused codes: drop the beat
                    endcase
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    out_load    = 1'b1;
                    n_out_value = i_rd_data;
                    n_out_last  = at_end;
                    // Advance to the next word and fetch it
                    if (!at_end) begin
                        n_ptr      = r_up ? (r_ptr + ADDR_W'(1)) : (r_ptr - ADDR_W'(1));
                        o_mem.re   = 1'b1;
                        o_mem.addr = n_ptr;
                    end
                end
            end
            default: ;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt_one   <= '0;
            r_cnt_two   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cnt_one <= n_cnt_one;
            r_cnt_two <= n_cnt_two;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_ptr <= n_ptr;
        r_end <= n_end;
        r_up  <= n_up;
        if (out_load) begin
            r_out_value  <= n_out_value;
            r_out_status <= n_out_status;
            r_out_last   <= n_out_last;
        end
    end

    assign o_rsp.valid  = r_out_valid;
    assign o_rsp.value  = r_out_value;
    assign o_rsp.status = r_out_status;
    assign o_rsp.last   = r_out_last;

endmodule
`default_nettype wire

// ----- hdl/two_stacks_shared_memory.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// two_stacks_shared_memory: two LIFO stacks in one shared memory
// Stack one grows up from word 0, stack two grows down from the top word.
// ----------------------------------------------------------------------------
// A push answers ok or overflow in one response beat. A pop reads the
// memory, whose read data is registered, and answers with the word or
// underflow. A list command streams one word per cycle from the top while
// the response channel is not stalled, the final beat marked by last; an
// empty stack gives one underflow beat. Commands are taken one at a time;
// the single memory read port sets the streaming rate. The memory needs no
// clearing after reset, so commands are taken at once.
// ----------------------------------------------------------------------------
module two_stacks_shared_memory import tssm_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    tssm_cmd_if.sink   i_cmd,
    tssm_rsp_if.source o_rsp
);

    t_mem_req          mem_req;
    logic [DATA_W-1:0] rd_data;

    // Sequencer
    tssm_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (i_cmd),
        .o_rsp     (o_rsp),
        .o_mem     (mem_req),
        .i_rd_data (rd_data)
    );

    // Shared stack memory
    tssm_ram #(
        .WORDS  (DEPTH),
        .ADDR_W (ADDR_W),
        .DATA_W (DATA_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_req.we),
        .i_waddr (mem_req.addr),
        .i_wdata (mem_req.wdata),
        .i_re    (mem_req.re),
        .i_raddr (mem_req.addr),
        .o_rdata (rd_data)
    );

endmodule
`default_nettype wire

// ----- hdl/tssm_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tssm_checker: port-level checks for the two-stack memory
// Watches the response channel and reset behavior.
// ----------------------------------------------------------------------------
module tssm_checker import tssm_pkg::*; (
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              i_rsp_valid,
    input wire logic              i_rsp_ready,
    input wire logic [DATA_W-1:0] i_rsp_value,
    input wire logic [STAT_W-1:0] i_rsp_status,
    input wire logic              i_rsp_last
);

    // Hold a stalled response beat
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid)
        else $error("response beat dropped while stalled");

    // Drop any response after reset
    a_rst_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_rsp_valid)
        else $error("response valid after reset");

    // Error beats end the command and carry no word
    a_err_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_rsp_status != ST_OK |-> i_rsp_last && i_rsp_value == '0)
        else $error("error beat not final or carries data");

    // Status stays within the defined codes
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> (i_rsp_status == ST_OK || i_rsp_status == ST_OVER ||
                         i_rsp_status == ST_UNDER))
        else $error("undefined status code");

endmodule

bind two_stacks_shared_memory tssm_checker u_tssm_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_rsp_valid  (o_rsp.valid),
    .i_rsp_ready  (o_rsp.ready),
    .i_rsp_value  (o_rsp.value),
    .i_rsp_status (o_rsp.status),
    .i_rsp_last   (o_rsp.last)
);
`default_nettype wire
